[rtl/ipc_pkg.sv]
// Shared types and constants for the interval profiling counters.
// Holds field widths, command codes and the request/result structs.
// No dependencies.
package ipc_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned WordW  = 32;

  // Codes above CmdRead behave as read.
  typedef enum logic [CmdW-1:0] {
    CmdStart = 3'd0,
    CmdEnd   = 3'd1,
    CmdAdd   = 3'd2,
    CmdClear = 3'd3,
    CmdRead  = 3'd4
  } ipc_cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [SlotW-1:0] slot;
    logic [WordW-1:0] timestamp;
    logic [WordW-1:0] byte_amount;
  } ipc_req_t;

  typedef struct packed {
    logic [WordW-1:0] elapsed_cycles;
    logic             overlap;
    logic [WordW-1:0] event_count;
    logic [WordW-1:0] cycle_total;
    logic [WordW-1:0] cycle_max;
    logic [WordW-1:0] byte_total;
  } ipc_rsp_t;

endpackage

[rtl/ipc_if.sv]
// Valid/ready channel interfaces for profiling requests and slot results.
// Depends on ipc_pkg for field widths.
interface ipc_req_if;
  logic                       valid;
  logic                       ready;
  logic [ipc_pkg::CmdW-1:0]   cmd;
  logic [ipc_pkg::SlotW-1:0]  slot;
  logic [ipc_pkg::WordW-1:0]  timestamp;
  logic [ipc_pkg::WordW-1:0]  byte_amount;

  modport source (output valid, cmd, slot, timestamp, byte_amount, input ready);
  modport sink   (input valid, cmd, slot, timestamp, byte_amount, output ready);
endinterface

interface ipc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ipc_pkg::WordW-1:0]  elapsed_cycles;
  logic                       overlap;
  logic [ipc_pkg::WordW-1:0]  event_count;
  logic [ipc_pkg::WordW-1:0]  cycle_total;
  logic [ipc_pkg::WordW-1:0]  cycle_max;
  logic [ipc_pkg::WordW-1:0]  byte_total;

  modport source (output valid, elapsed_cycles, overlap, event_count, cycle_total,
                  cycle_max, byte_total, input ready);
  modport sink   (input valid, elapsed_cycles, overlap, event_count, cycle_total,
                  cycle_max, byte_total, output ready);
endinterface

[rtl/interval_profiling_counters.sv]
// Top level of the interval profiling counters.
// Depends on ipc_pkg, ipc_req_if/ipc_rsp_if and ipc_slot_table.

// Interval profiling counters: a table of NUM_SLOTS slots, each holding a
// start stamp, running flag, interval count, cycle total, cycle maximum and
// byte total. Every request (start, end, add bytes, clear, read) returns one
// result: the addressed slot's statistics after the request, with the elapsed
// cycles for an end and the overlap flag for a start. A request whose slot is
// at or beyond NUM_SLOTS changes nothing and returns all zeros; command codes
// past read act as read. Throughput is one request per clock while the result
// side does not stall; the accepting edge loads the input register, and the
// slot table's read-modify-write then writes the result register as the
// request leaves the input register.
// All slot state is in flip-flops cleared by reset, so the block takes requests
// right after reset with no initialization pass. Back-pressure on the result
// side stalls the input register and then the request channel.
module interval_profiling_counters #(
  parameter int unsigned NUM_SLOTS = ipc_pkg::NumSlotsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipc_req_if.sink   req_i,
  ipc_rsp_if.source rsp_o
);
  import ipc_pkg::*;

  // Input register stage.
  logic     s1_valid_q, s1_valid_d;
  ipc_req_t s1_req_q;

  // Result register stage.
  logic     rsp_valid_q, rsp_valid_d;
  ipc_rsp_t rsp_q;
  ipc_rsp_t tbl_rsp;

  logic req_acc;
  logic rsp_free;
  logic s1_adv;

  // Result slot can take a new value when empty or being drained.
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  // State update happens on the same edge the request moves to the result reg,
  // so the next request in the input stage sees the updated slot.
  assign s1_adv      = s1_valid_q && rsp_free;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (s1_adv) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_req_q.cmd         <= req_i.cmd;
      s1_req_q.slot        <= req_i.slot;
      s1_req_q.timestamp   <= req_i.timestamp;
      s1_req_q.byte_amount <= req_i.byte_amount;
    end
    if (s1_adv) begin
      rsp_q <= tbl_rsp;
    end
  end

  ipc_slot_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (s1_adv),
    .req_i    (s1_req_q),
    .rsp_o    (tbl_rsp)
  );

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.elapsed_cycles = rsp_q.elapsed_cycles;
  assign rsp_o.overlap        = rsp_q.overlap;
  assign rsp_o.event_count    = rsp_q.event_count;
  assign rsp_o.cycle_total    = rsp_q.cycle_total;
  assign rsp_o.cycle_max      = rsp_q.cycle_max;
  assign rsp_o.byte_total     = rsp_q.byte_total;

endmodule

[rtl/ipc_slot_table.sv]
// Per-slot profiling state and its read-modify-write update.
// Depends on ipc_pkg for request/result types and command codes.
module ipc_slot_table #(
  parameter int unsigned NUM_SLOTS = ipc_pkg::NumSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_en_i,
  input  ipc_pkg::ipc_req_t req_i,
  output ipc_pkg::ipc_rsp_t rsp_o
);
  import ipc_pkg::*;

  // The slot field can reach at most 2^SlotW entries.
  localparam int unsigned Depth = (NUM_SLOTS < (1 << SlotW)) ? NUM_SLOTS : (1 << SlotW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [WordW-1:0] stamp_q [Depth];
  logic [Depth-1:0] running_q;
  logic [WordW-1:0] cnt_q   [Depth];
  logic [WordW-1:0] sum_q   [Depth];
  logic [WordW-1:0] peak_q  [Depth];
  logic [WordW-1:0] bytes_q [Depth];

  logic             in_range;
  logic [IdxW-1:0]  idx;
  logic [WordW-1:0] elapsed;
  logic [WordW-1:0] cnt_d, sum_d, peak_d, bytes_d;

  assign in_range = int'(req_i.slot) < int'(Depth);
  assign idx      = IdxW'(req_i.slot);
  assign elapsed  = req_i.timestamp - stamp_q[idx];

  always_comb begin
    cnt_d   = cnt_q[idx];
    sum_d   = sum_q[idx];
    peak_d  = peak_q[idx];
    bytes_d = bytes_q[idx];
    rsp_o   = '0;
    case (req_i.cmd)
      CmdStart: begin
        rsp_o.overlap = running_q[idx];
      end
      CmdEnd: begin
        cnt_d = cnt_q[idx] + WordW'(1);
        sum_d = sum_q[idx] + elapsed;
        if (elapsed > peak_q[idx]) begin
          peak_d = elapsed;
        end
        rsp_o.elapsed_cycles = elapsed;
      end
      CmdAdd: begin
        bytes_d = bytes_q[idx] + req_i.byte_amount;
      end
      CmdClear: begin
        cnt_d   = '0;
        sum_d   = '0;
        peak_d  = '0;
        bytes_d = '0;
      end
      default: ;
    endcase
    rsp_o.event_count = cnt_d;
    rsp_o.cycle_total = sum_d;
    rsp_o.cycle_max   = peak_d;
    rsp_o.byte_total  = bytes_d;
    if (!in_range) begin
      rsp_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      for (int i = 0; i < int'(Depth); i++) begin
        stamp_q[i] <= '0;
        cnt_q[i]   <= '0;
        sum_q[i]   <= '0;
        peak_q[i]  <= '0;
        bytes_q[i] <= '0;
      end
    end else if (upd_en_i && in_range) begin
      case (req_i.cmd)
        CmdStart: begin
          running_q[idx] <= 1'b1;
          stamp_q[idx]   <= req_i.timestamp;
        end
        CmdEnd: begin
          running_q[idx] <= 1'b0;
          cnt_q[idx]     <= cnt_d;
          sum_q[idx]     <= sum_d;
          peak_q[idx]    <= peak_d;
        end
        CmdAdd: begin
          bytes_q[idx] <= bytes_d;
        end
        CmdClear: begin
          for (int i = 0; i < int'(Depth); i++) begin
            cnt_q[i]   <= '0;
            sum_q[i]   <= '0;
            peak_q[i]  <= '0;
            bytes_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Overlap is only ever reported for a start request.
  a_overlap_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.overlap |-> (req_i.cmd == CmdStart))
    else $error("overlap flagged on non-start request");

  // A nonzero interval is only ever reported for an end request.
  a_elapsed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.elapsed_cycles != '0) |-> (req_i.cmd == CmdEnd))
    else $error("elapsed reported on non-end request");

  // After an end, the slot's peak covers the measured interval and it is idle.
  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en_i && in_range && req_i.cmd == CmdEnd) |=>
      (peak_q[$past(idx)] >= $past(elapsed)) && !running_q[$past(idx)])
    else $error("peak or running flag wrong after end");

  // After a start the slot is running with the new stamp.
  a_start_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en_i && in_range && req_i.cmd == CmdStart) |=>
      running_q[$past(idx)] && (stamp_q[$past(idx)] == $past(req_i.timestamp)))
    else $error("start did not stamp slot");
`endif

endmodule

[tb/sv/interval_profiling_counters_test.sv]
// Self-checking testbench for interval_profiling_counters: directed and random
// profiling requests with random stalls on both channels, checked per field.
// Depends on ipc_pkg, ipc_req_if/ipc_rsp_if and the interval_profiling_counters RTL.

// Slot table mirror: predicts one result per accepted request and checks
// results in arrival order.
class profile_scoreboard;
  int unsigned num_slots;
  bit [ipc_pkg::WordW-1:0] launch_stamp [];
  bit                      busy [];
  bit [ipc_pkg::WordW-1:0] done_count [];
  bit [ipc_pkg::WordW-1:0] cyc_sum [];
  bit [ipc_pkg::WordW-1:0] cyc_peak [];
  bit [ipc_pkg::WordW-1:0] byte_sum [];
  ipc_pkg::ipc_rsp_t       expected_results [$];
  int unsigned             mismatches;

  function new(int unsigned n);
    num_slots    = n;
    launch_stamp = new[n];
    busy         = new[n];
    done_count   = new[n];
    cyc_sum      = new[n];
    cyc_peak     = new[n];
    byte_sum     = new[n];
    mismatches   = 0;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // Work out the slot update for one accepted request and queue its result.
  function void note_request(ipc_pkg::ipc_req_t r);
    ipc_pkg::ipc_rsp_t p;
    int unsigned s;
    p = '0;
    s = r.slot;
    if (s < num_slots) begin
      case (r.cmd)
        ipc_pkg::CmdStart: begin
          p.overlap       = busy[s];
          busy[s]         = 1'b1;
          launch_stamp[s] = r.timestamp;
        end
        ipc_pkg::CmdEnd: begin
          // end without start measures from whatever stamp is held
          p.elapsed_cycles = r.timestamp - launch_stamp[s];
          busy[s]          = 1'b0;
          done_count[s]    = done_count[s] + 1'b1;
          cyc_sum[s]       = cyc_sum[s] + p.elapsed_cycles;
          if (p.elapsed_cycles > cyc_peak[s]) cyc_peak[s] = p.elapsed_cycles;
        end
        ipc_pkg::CmdAdd: byte_sum[s] = byte_sum[s] + r.byte_amount;
        ipc_pkg::CmdClear: begin
          // stamps and running flags survive a clear
          foreach (done_count[k]) begin
            done_count[k] = '0;
            cyc_sum[k]    = '0;
            cyc_peak[k]   = '0;
            byte_sum[k]   = '0;
          end
        end
        default: ;
      endcase
      p.event_count = done_count[s];
      p.cycle_total = cyc_sum[s];
      p.cycle_max   = cyc_peak[s];
      p.byte_total  = byte_sum[s];
    end
    expected_results.push_back(p);
  endfunction

  function void report_field(string name, logic [ipc_pkg::WordW-1:0] want,
                             logic [ipc_pkg::WordW-1:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, seen);
    end
  endfunction

  function void check_result(ipc_pkg::ipc_rsp_t got);
    ipc_pkg::ipc_rsp_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result with no request outstanding", $realtime);
      return;
    end
    want = expected_results.pop_front();
    report_field("elapsed_cycles", want.elapsed_cycles, got.elapsed_cycles);
    report_field("overlap", {31'b0, want.overlap}, {31'b0, got.overlap});
    report_field("event_count", want.event_count, got.event_count);
    report_field("cycle_total", want.cycle_total, got.cycle_total);
    report_field("cycle_max", want.cycle_max, got.cycle_max);
    report_field("byte_total", want.byte_total, got.byte_total);
  endfunction
endclass

module interval_profiling_counters_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ipc_pkg::*;

  localparam int unsigned NUM_SLOTS   = NumSlotsDefault;
  localparam int unsigned RAND_ITEMS  = 1880;
  localparam int unsigned QUIET_ITEMS = 200;   // tail of the run with no idling
  localparam int unsigned DRAIN_WAIT  = 10;    // extra wait after all results are back

  logic clk_i;
  logic rst_ni;

  ipc_req_if req_bus ();
  ipc_rsp_if rsp_bus ();

  interval_profiling_counters #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  profile_scoreboard sb;
  ipc_rsp_t          seen_rsp;
  bit                quiet;                    // set for the final stretch: no stalls
  bit [WordW-1:0]    clock_now;                // model timestamp for the random requests

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("interval_profiling_counters_test: errors");
    $finish;
  end

  // Result side back-pressure: random stall bursts until the quiet tail.
  initial begin
    rsp_bus.ready = 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    rsp_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Result monitor. Sampled right after the edge, so these are pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      seen_rsp.elapsed_cycles = rsp_bus.elapsed_cycles;
      seen_rsp.overlap        = rsp_bus.overlap;
      seen_rsp.event_count    = rsp_bus.event_count;
      seen_rsp.cycle_total    = rsp_bus.cycle_total;
      seen_rsp.cycle_max      = rsp_bus.cycle_max;
      seen_rsp.byte_total     = rsp_bus.byte_total;
      sb.check_result(seen_rsp);
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] slot,
                              input logic [WordW-1:0] ts, input logic [WordW-1:0] amount);
    ipc_req_t r;
    r.cmd         = cmd;
    r.slot        = slot;
    r.timestamp   = ts;
    r.byte_amount = amount;
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= cmd;
    req_bus.slot        <= slot;
    req_bus.timestamp   <= ts;
    req_bus.byte_amount <= amount;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(r);
  endtask

  // Sender gap: drop valid for a random burst now and then.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Mostly start/end traffic so slots accumulate real intervals.
  function automatic logic [CmdW-1:0] pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 32)      return CmdStart;
    else if (roll < 64) return CmdEnd;
    else if (roll < 80) return CmdAdd;
    else if (roll < 94) return CmdRead;
    else if (roll < 97) return CmdClear;
    else                return CmdW'($urandom_range(int'(CmdRead) + 1, 2**CmdW - 1));
  endfunction

  initial begin
    logic [CmdW-1:0]  cmd;
    logic [SlotW-1:0] slot;
    logic [WordW-1:0] amount;
    int               c;

    sb    = new(NUM_SLOTS);
    quiet = 1'b0;
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.cmd         = CmdRead;
    req_bus.slot        = '0;
    req_bus.timestamp   = '0;
    req_bus.byte_amount = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    send_request(CmdRead,  4'd0, '0, '0);                 // fresh slot reads zero
    send_request(CmdEnd,   4'd1, 32'd5, '0);              // end with no start
    send_request(CmdStart, 4'd2, 32'hFFFF_FFF0, '0);
    send_request(CmdStart, 4'd2, 32'hFFFF_FFF8, '0);      // overlap on running slot
    send_request(CmdEnd,   4'd2, 32'h0000_0010, '0);      // interval across timestamp wrap
    send_request(CmdAdd,   4'd3, '0, 32'hFFFF_FFFF);
    send_request(CmdAdd,   4'd3, '0, 32'd2);              // byte total wraps
    send_request(CmdAdd,   4'd0, '1, '0);
    send_request(CmdStart, 4'd15, '0, '1);
    send_request(CmdEnd,   4'd15, 32'hFFFF_FFFF, '1);     // largest interval
    send_request(CmdStart, 4'd15, '0, '0);
    send_request(CmdEnd,   4'd15, 32'hFFFF_FFFF, '0);     // cycle total wraps
    send_request(CmdStart, 4'd7, 32'h1234_5678, '0);
    send_request(CmdEnd,   4'd7, 32'h1234_5678, '0);      // zero-length interval
    send_request(CmdStart, 4'd4, 32'hA5A5_5A5A, '0);
    send_request(CmdClear, 4'd5, '0, '0);                 // wipes stats, keeps stamps
    send_request(CmdRead,  4'd15, '0, '0);
    send_request(CmdStart, 4'd4, 32'h5A5A_A5A5, '0);      // still running after clear
    send_request(CmdEnd,   4'd4, 32'hFFFF_0000, '0);
    send_request(CmdEnd,   4'd2, 32'h0000_0100, '0);      // end on idle slot after clear
    for (c = int'(CmdRead) + 1; c < 2**CmdW; c++)
      send_request(CmdW'(c), 4'd4, '1, '1);               // spare codes behave as read
    send_request(CmdRead,  4'd4, '0, '0);

    // Hold off until the block has answered everything outstanding.
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // ---- random part ----
    clock_now = $urandom;
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      sender_gap();
      cmd  = pick_cmd();
      slot = ($urandom_range(0, 1) == 0) ? SlotW'($urandom_range(0, 3)) : SlotW'($urandom);
      amount = ($urandom_range(0, 3) == 0) ? WordW'($urandom) : WordW'($urandom_range(0, 4096));
      // time moves forward mostly in small steps, with the odd jump anywhere
      if ($urandom_range(0, 19) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(0, 300);
      send_request(cmd, slot, clock_now, amount);
    end

    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("interval_profiling_counters_test: clean");
    end else begin
      $display("interval_profiling_counters_test: errors");
    end
    $finish;
  end

endmodule
